[design/rational_arithmetic_unit_macros.svh]
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[design/rau_pkg.sv]
// types and constants shared by the rational arithmetic unit
`default_nettype none
package rau_pkg;
    localparam logic [1:0] K_ADD = 2'd0;
    localparam logic [1:0] K_SUB = 2'd1;
    localparam logic [1:0] K_MUL = 2'd2;
    localparam logic [1:0] K_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic signed [63:0] res_den;
        logic               error;
    } t_out;

    // unreduced fraction handed from front to back
    typedef struct packed {
        logic [63:0] num;
        logic [63:0] den;
    } t_frac;
endpackage
`default_nettype wire

[design/rational_arithmetic_unit.sv]
// rational arithmetic unit: cross multiplication, binary gcd, then 128 divide steps
// front multiplies in states P1 and P2 and presents in OUT, back runs binary gcd one step per cycle then
// two 64-step restoring divisions; back loop sets throughput, it takes no new item until its result is taken
// a zero denominator skips the back loop: the back goes from idle straight to its output state
// a two-beat queue lets the front take the next item while the back works
// synchronous active-low reset clears all control state, queue empties
`default_nettype none
`include "rational_arithmetic_unit_macros.svh"
module rational_arithmetic_unit (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  rau_pkg::t_in  i_data,
    output logic          o_valid,
    input  wire           i_ready,
    output rau_pkg::t_out o_data
);
    logic           w_fv, w_fr, w_qv, w_qr;
    rau_pkg::t_frac w_fd, w_qd;

    rau_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_valid(w_fv), .i_ready(w_fr), .o_data(w_fd)
    );
    rau_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_data(w_fd),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qd)
    );
    rau_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_data(w_qd),
        .o_valid, .i_ready, .o_data
    );

    `RAU_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_valid && o_data.error,
        o_data.res_num == 64'sd0 && o_data.res_den == 64'sd0)
    `RAU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_data))
    `RAU_ASSERT_IMPL(a_nonzero_den, i_clk, i_rst_n, o_valid && !o_data.error,
        o_data.res_den != 64'sd0)
endmodule
`default_nettype wire

[design/rau_front.sv]
// front end: cross multiplication to an unreduced 64-bit fraction
`default_nettype none
module rau_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  rau_pkg::t_in   i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output rau_pkg::t_frac o_data
);
    // states: 0 idle, 1 first product pair, 2 denominator product, 3 combine
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_P1   = 2'd1;
    localparam logic [1:0] S_P2   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]    r_state, n_state;
    rau_pkg::t_in  r_in;
    logic [63:0]   r_p0, r_p1, r_p2;
    logic [63:0]   w_x0, w_y0, w_x1, w_y1, w_m0, w_m1;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    // operand selection for two 32x32 multipliers per cycle
    always_comb begin
        w_x0 = 64'(r_in.a_num);
        w_y0 = 64'(r_in.b_den);
        w_x1 = 64'(r_in.b_num);
        w_y1 = 64'(r_in.a_den);
        if (r_state == S_P1) begin
            case (r_in.kind)
                rau_pkg::K_MUL: w_y0 = 64'(r_in.b_num);
                default:        w_y0 = 64'(r_in.b_den);
            endcase
        end else begin
            w_x0 = 64'(r_in.a_den);
            case (r_in.kind)
                rau_pkg::K_DIV: w_y0 = 64'(r_in.b_num);
                default:        w_y0 = 64'(r_in.b_den);
            endcase
        end
        w_m0 = 64'($signed(w_x0[31:0]) * $signed(w_y0[31:0]));
        w_m1 = 64'($signed(w_x1[31:0]) * $signed(w_y1[31:0]));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_P1;
            S_P1:    n_state = S_P2;
            S_P2:    n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == S_IDLE && i_valid) r_in <= i_data;
        if (r_state == S_P1) begin
            r_p0 <= w_m0;
            r_p1 <= w_m1;
        end
        if (r_state == S_P2) r_p2 <= w_m0;
    end

    always_comb begin
        o_data.den = r_p2;
        case (r_in.kind)
            rau_pkg::K_ADD: o_data.num = r_p0 + r_p1;
            rau_pkg::K_SUB: o_data.num = r_p0 - r_p1;
            default:        o_data.num = r_p0;
        endcase
    end
endmodule
`default_nettype wire

[design/rau_fifo.sv]
// two-entry queue between front and back
`default_nettype none
module rau_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  rau_pkg::t_frac i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output rau_pkg::t_frac o_data
);
    rau_pkg::t_frac r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

[design/rau_back.sv]
// back end: gcd by binary euclid, two restoring divisions, sign fixup
`default_nettype none
module rau_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  rau_pkg::t_frac i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output rau_pkg::t_out  o_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIVN = 3'd2;
    localparam logic [2:0] S_DIVD = 3'd3;
    localparam logic [2:0] S_FIX  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]   r_state, n_state;
    logic [63:0]  r_num, r_den, r_x, r_y, r_g, r_q, r_rem;
    logic [6:0]   r_sh;
    logic [5:0]   r_bit;
    logic         r_err;
    logic [63:0]  w_mn, w_md, w_dv, w_sub;
    logic [64:0]  w_trial;
    logic [63:0]  w_qn;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign w_mn = i_data.num[63] ? (64'd0 - i_data.num) : i_data.num;
    assign w_md = i_data.den[63] ? (64'd0 - i_data.den) : i_data.den;
    // dividend magnitude for the current division
    assign w_dv = (r_state == S_DIVN) ? (r_num[63] ? 64'd0 - r_num : r_num)
                                      : (r_den[63] ? 64'd0 - r_den : r_den);
    assign w_trial = {r_rem, w_dv[r_bit]};
    assign w_sub   = w_trial[63:0] - r_g;
    assign w_qn    = {r_q[62:0], (w_trial >= {1'b0, r_g})};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = (i_data.den == 64'd0) ? S_OUT : S_GCD;
            S_GCD:   if (r_y == 64'd0 || r_x == 64'd0) n_state = S_DIVN;
            S_DIVN:  if (r_bit == 6'd0) n_state = S_DIVD;
            S_DIVD:  if (r_bit == 6'd0) n_state = S_FIX;
            S_FIX:   n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            S_IDLE: begin
                r_num <= i_data.num;
                r_den <= i_data.den;
                r_err <= (i_data.den == 64'd0);
                r_x   <= w_mn;
                r_y   <= w_md;
                r_sh  <= 7'd0;
            end
            S_GCD: begin
                // binary gcd: one step per cycle
                if (r_x == 64'd0 || r_y == 64'd0) begin
                    r_g   <= (r_x | r_y) << r_sh[5:0];
                    r_bit <= 6'd63;
                    r_q   <= 64'd0;
                    r_rem <= 64'd0;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x  <= r_x >> 1;
                    r_y  <= r_y >> 1;
                    r_sh <= r_sh + 7'd1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= r_x - r_y;
                end else begin
                    r_y <= r_y - r_x;
                end
            end
            S_DIVN, S_DIVD: begin
                if (r_bit != 6'd0) begin
                    r_rem <= (w_trial >= {1'b0, r_g}) ? w_sub : w_trial[63:0];
                    r_q   <= w_qn;
                    r_bit <= r_bit - 6'd1;
                end else if (r_state == S_DIVN) begin
                    r_num <= r_num[63] ? 64'd0 - w_qn : w_qn;
                    r_q   <= 64'd0;
                    r_rem <= 64'd0;
                    r_bit <= 6'd63;
                end else begin
                    r_den <= r_den[63] ? 64'd0 - w_qn : w_qn;
                end
            end
            S_FIX: begin
                if (r_num[63] && r_den[63]) begin
                    r_num <= 64'd0 - r_num;
                    r_den <= 64'd0 - r_den;
                end
            end
            default: ;
        endcase
    end

    assign o_data.res_num = r_err ? 64'sd0 : $signed(r_num);
    assign o_data.res_den = r_err ? 64'sd0 : $signed(r_den);
    assign o_data.error   = r_err;
endmodule
`default_nettype wire
